>>> src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Sizes of the bucket table and node pool, field widths, status and op codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

  // table sizes
  localparam int unsigned SLOTS = 64;
  localparam int unsigned NODES = 1024;

  // field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 7;

  // derived widths
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PTR_W  = $clog2(NODES + 1);

  // null marker of a chain link
  localparam logic [PTR_W-1:0] EMPTY_PTR = PTR_W'(NODES);

  // modulo unit: digits of the magnitude consumed per cycle
  localparam int unsigned MOD_DIG   = 4;
  localparam int unsigned MOD_STEPS = KEY_W / MOD_DIG;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_e;

  // one pool entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] first;
    logic [PTR_W-1:0] next;
  } node_t;

endpackage

`default_nettype wire

>>> src/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table: hash table with separate chaining and a bounded pool
// Buckets are key magnitude modulo the slot count; inserts push at the chain
// head, searches walk the chain and return the first matching node.
// ----------------------------------------------------------------------------
// steps: request capture, modulo unit (4 key bits per cycle), head read, head data;
//   a search then walks the chain, one node memory read per cycle, none if empty
// requests: one at a time; a new request is taken only once the previous result
//   has entered the output register, which waits while the output is stalled
// reset: bucket heads read as empty through 64 valid flops cleared at once,
//   pool count zero, slot count 64; no clearing pass, ready right after reset
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [cht_pkg::CFG_W-1:0] cfg_data_i,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     operation_i,
  input  wire logic signed [cht_pkg::KEY_W-1:0] key_i,
  input  wire logic [cht_pkg::IDX_W-1:0] first_index_i,
  input  wire logic [cht_pkg::IDX_W-1:0] second_index_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [cht_pkg::STATUS_W-1:0]  status_o,
  output logic [cht_pkg::IDX_W-1:0]     found_first_index_o,
  output logic [cht_pkg::IDX_W-1:0]     found_second_index_o
);

  import cht_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_HEAD = 6'b000100,
    S_HDAT = 6'b001000,
    S_WALK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  slot_cnt_q;
  logic [CFG_W-1:0]  eff_slots;

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  first_q, second_q;
  logic [KEY_W-1:0]  mag_q, mag_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [SLOT_W-1:0] bucket;

  logic [SLOTS-1:0]  head_vld_q;
  logic [PTR_W-1:0]  used_q;
  logic [PTR_W-1:0]  steps_q;

  logic [PTR_W-1:0]  head_rdata;
  logic [PTR_W-1:0]  head_ptr;
  logic              head_we;

  node_t             node_rdata;
  node_t             node_wdata;
  logic [NODE_W-1:0] node_raddr;
  logic              node_we;

  status_e           res_status_q;
  logic [IDX_W-1:0]  res_first_q, res_second_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [IDX_W-1:0]  out_first_q, out_second_q;

  logic              in_acc;
  logic              out_free;
  logic              pool_full;
  logic              key_hit;
  logic              walk_end;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q <= CFG_W'(SLOTS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      slot_cnt_q <= cfg_data_i;
    end
  end

  // divisor: zero counts as one, large values saturate
  always_comb begin
    if (slot_cnt_q == '0) begin
      eff_slots = CFG_W'(1);
    end else if (32'(slot_cnt_q) > SLOTS) begin
      eff_slots = CFG_W'(SLOTS);
    end else begin
      eff_slots = slot_cnt_q;
    end
  end

  // modulo unit: restoring remainder, MOD_DIG key bits per cycle
  always_comb begin
    logic [CFG_W:0] tmp;
    rem_d = rem_q;
    for (int i = 0; i < int'(MOD_DIG); i++) begin
      tmp = {rem_d, mag_q[KEY_W-1-i]};
      if (tmp >= {1'b0, eff_slots}) begin
        tmp = tmp - {1'b0, eff_slots};
      end
      rem_d = tmp[CFG_W-1:0];
    end
    mag_d = mag_q << MOD_DIG;
  end

  assign bucket = SLOT_W'(rem_q);

  // head memory, an unwritten bucket reads as empty
  cht_ram #(
    .WIDTH (PTR_W),
    .DEPTH (SLOTS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (bucket),
    .wdata_i (used_q),
    .raddr_i (bucket),
    .rdata_o (head_rdata)
  );

  assign head_ptr  = head_vld_q[bucket] ? head_rdata : EMPTY_PTR;
  assign pool_full = (used_q == PTR_W'(NODES));
  assign head_we   = (state_q == S_HDAT) && (op_q == OP_INSERT) && !pool_full;
  assign node_we   = head_we;

  // node pool memory
  always_comb begin
    node_wdata.key    = key_q;
    node_wdata.second = second_q;
    node_wdata.first  = first_q;
    node_wdata.next   = head_ptr;
  end

  assign node_raddr = (state_q == S_WALK) ? node_rdata.next[NODE_W-1:0]
                                          : head_ptr[NODE_W-1:0];

  cht_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (used_q[NODE_W-1:0]),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // chain walk compare
  assign key_hit  = (node_rdata.key == key_q);
  assign walk_end = (node_rdata.next == EMPTY_PTR) || (steps_q + 1'b1 == PTR_W'(NODES));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_MOD;
      end
      S_MOD: begin
        if (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) state_d = S_HEAD;
      end
      S_HEAD: begin
        state_d = S_HDAT;
      end
      S_HDAT: begin
        if (op_q == OP_SEARCH && head_ptr != EMPTY_PTR) begin
          state_d = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (key_hit || walk_end) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_vld_q  <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (head_we) begin
        head_vld_q[bucket] <= 1'b1;
        used_q             <= used_q + 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, modulo progress and walk counter
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= operation_i;
      key_q     <= key_i;
      first_q   <= first_index_i;
      second_q  <= second_index_i;
      mag_q     <= key_i[KEY_W-1] ? (~key_i + 1'b1) : key_i;
      rem_q     <= '0;
      mod_cnt_q <= '0;
    end else if (state_q == S_MOD) begin
      mag_q     <= mag_d;
      rem_q     <= rem_d;
      mod_cnt_q <= mod_cnt_q + 1'b1;
    end
    if (state_q == S_HDAT) begin
      steps_q <= '0;
    end else if (state_q == S_WALK) begin
      steps_q <= steps_q + 1'b1;
    end
  end

  // result of the request
  always_ff @(posedge clk_i) begin
    if (state_q == S_HDAT) begin
      res_first_q  <= '0;
      res_second_q <= '0;
      if (op_q == OP_INSERT) begin
        res_status_q <= pool_full ? ST_POOL_FULL : ST_INSERTED;
      end else begin
        res_status_q <= ST_NOT_FOUND;
      end
    end else if (state_q == S_WALK && key_hit) begin
      res_status_q <= ST_FOUND;
      res_first_q  <= node_rdata.first;
      res_second_q <= node_rdata.second;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign found_first_index_o  = out_first_q;
  assign found_second_index_o = out_second_q;

endmodule

`default_nettype wire

>>> src/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker: port-level checks of the chained hash table
// Watches handshakes and result fields, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cht_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [cht_pkg::STATUS_W-1:0] status_o,
  input wire logic [cht_pkg::IDX_W-1:0]    found_first_index_o,
  input wire logic [cht_pkg::IDX_W-1:0]    found_second_index_o
);

  import cht_pkg::*;

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(status_o) && $stable(found_first_index_o) && $stable(found_second_index_o))
    else $error("result changed while stalled");

  // one request in flight: busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // index fields are zero unless a match was found
  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |->
      found_first_index_o == '0 && found_second_index_o == '0)
    else $error("index fields set without a match");

endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);

`default_nettype wire
